// ===== sv/rth_pkg.sv =====
// Package: pixel payload types and hue sextant codes for the RGB to HSV converter.
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

    // Port field widths
    localparam int unsigned CHAN_W = 16;
    localparam int unsigned HUE_W  = 15;

    // One RGB pixel request
    typedef struct packed {
        logic [CHAN_W-1:0] red_level;
        logic [CHAN_W-1:0] green_level;
        logic [CHAN_W-1:0] blue_level;
    } rth_pixel_t;

    // One HSV result
    typedef struct packed {
        logic [HUE_W-1:0]  hue_angle;
        logic [CHAN_W-1:0] saturation_level;
        logic [CHAN_W-1:0] value_level;
    } rth_hsv_t;

    // Channel that holds the maximum, picks the hue offset
    typedef enum logic [1:0] {
        SEXT_RED,
        SEXT_GREEN,
        SEXT_BLUE
    } rth_sextant_t;

    // Hue offsets in whole degrees
    localparam int unsigned OFFSET_GREEN = 120;
    localparam int unsigned OFFSET_BLUE  = 240;
    localparam int unsigned FULL_TURN    = 360;
    localparam int unsigned SEXT_SPAN    = 60;

endpackage

`default_nettype wire

// ===== sv/rgb_to_hsv_convert.sv =====
// Top level: RGB to HSV pixel converter built as a chain of divider cells.
//
//   channel | direction | payload              | handshake
//   --------+-----------+----------------------+-----------------------
//   in      | sink      | rth_pixel_t (r,g,b)  | in_valid / in_ready
//   out     | source    | rth_hsv_t (h,s,v)    | out_valid / out_ready
//
// One pixel is taken per clock unless the output stalls. A result passes prep stages
// A and B, QB divider cells and the output register; QB is the larger of CHANNEL_BITS
// and the hue quotient width (16 at the defaults). Each divider cell yields one
// quotient bit for both lanes. Reset clears only the stage valid flags; no clearing
// pass is needed. A stall at the output backs up stage by stage, so empty stages still fill.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_convert #(
    parameter int unsigned CHANNEL_BITS      = 16,
    parameter int unsigned HUE_FRACTION_BITS = 6
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rth_pkg::rth_pixel_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rth_pkg::rth_hsv_t        out_data
);

    localparam int unsigned CB     = CHANNEL_BITS;
    localparam int unsigned HQB    = $clog2(60*(2**HUE_FRACTION_BITS)+1);
    localparam int unsigned QB     = (CB > HQB) ? CB : HQB;
    localparam int unsigned DW     = CB + 1;
    localparam int unsigned LW     = 2*DW + QB;
    localparam int unsigned SIDE_W = CB + 4;

    logic [QB:0]             chain_valid;
    logic [QB:0]             chain_ready;
    logic [QB:0][LW-1:0]     chain_hue;
    logic [QB:0][LW-1:0]     chain_sat;
    logic [QB:0][SIDE_W-1:0] chain_side;

    // Front end
    rth_prep #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .down_valid (chain_valid[0]),
        .down_ready (chain_ready[0]),
        .lane_hue   (chain_hue[0]),
        .lane_sat   (chain_sat[0]),
        .side       (chain_side[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        rth_div_cell #(
            .DW     (DW),
            .QB     (QB),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (chain_valid[i]),
            .up_ready   (chain_ready[i]),
            .up_hue     (chain_hue[i]),
            .up_sat     (chain_sat[i]),
            .up_side    (chain_side[i]),
            .down_valid (chain_valid[i+1]),
            .down_ready (chain_ready[i+1]),
            .down_hue   (chain_hue[i+1]),
            .down_sat   (chain_sat[i+1]),
            .down_side  (chain_side[i+1])
        );
    end

    // Back end and output register
    rth_finish #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .DW                (DW),
        .QB                (QB)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (chain_valid[QB]),
        .up_ready  (chain_ready[QB]),
        .up_hue    (chain_hue[QB]),
        .up_sat    (chain_sat[QB]),
        .up_side   (chain_side[QB]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== sv/rth_prep.sv =====
// Front end: max, min and sextant pick, then dividend and divisor set-up.
`timescale 1ns / 1ps
`default_nettype none

module rth_prep #(
    parameter int unsigned CHANNEL_BITS      = 16,
    parameter int unsigned HUE_FRACTION_BITS = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire rth_pkg::rth_pixel_t                   in_data,
    output logic                                       down_valid,
    input  wire logic                                  down_ready,
    output logic [2*(CHANNEL_BITS+1)+(
        (CHANNEL_BITS > $clog2(60*(2**HUE_FRACTION_BITS)+1)) ? CHANNEL_BITS :
        $clog2(60*(2**HUE_FRACTION_BITS)+1))-1:0]      lane_hue,
    output logic [2*(CHANNEL_BITS+1)+(
        (CHANNEL_BITS > $clog2(60*(2**HUE_FRACTION_BITS)+1)) ? CHANNEL_BITS :
        $clog2(60*(2**HUE_FRACTION_BITS)+1))-1:0]      lane_sat,
    output logic [CHANNEL_BITS+3:0]                    side
);

    localparam int unsigned CB     = CHANNEL_BITS;
    localparam int unsigned HQB    = $clog2(60*(2**HUE_FRACTION_BITS)+1);
    localparam int unsigned QB     = (CB > HQB) ? CB : HQB;
    localparam int unsigned DW     = CB + 1;
    localparam int unsigned NW_SAT = 2*CB + 2;
    localparam int unsigned NW_HUE = CB + HUE_FRACTION_BITS + 8;
    localparam int unsigned NW     = (NW_SAT > NW_HUE) ? NW_SAT : NW_HUE;
    localparam int unsigned LW     = 2*DW + QB;
    localparam int unsigned HUE_SCALE2 = 2 * rth_pkg::SEXT_SPAN * (2**HUE_FRACTION_BITS);

    // Stage A registers
    logic                       a_valid_reg, a_valid_next;
    logic [CB-1:0]              mx_a_reg, mx_a_next;
    logic [CB-1:0]              mn_a_reg, mn_a_next;
    logic [CB-1:0]              x_a_reg, x_a_next;
    logic [CB-1:0]              y_a_reg, y_a_next;
    rth_pkg::rth_sextant_t      sel_a_reg, sel_a_next;

    // Stage B registers
    logic                       b_valid_reg, b_valid_next;
    logic [LW-1:0]              lane_hue_reg, lane_hue_next;
    logic [LW-1:0]              lane_sat_reg, lane_sat_next;
    logic [CB+3:0]              side_reg, side_next;

    logic                       a_ready;
    logic                       b_ready;
    logic [CB+rth_pkg::CHAN_W-1:0] r_wide, g_wide, b_wide;
    logic [CB-1:0]              r_lvl, g_lvl, b_lvl;
    logic [CB-1:0]              delta;
    logic [CB-1:0]              mag;
    logic                       neg;
    logic                       grey;
    logic [NW-1:0]              num_hue;
    logic [NW-1:0]              num_sat;
    logic [NW-1:0]              top_hue;
    logic [NW-1:0]              top_sat;

    // Handshake: a stage takes a request when empty or when it empties
    assign b_ready    = !b_valid_reg || down_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign in_ready   = a_ready;
    assign down_valid = b_valid_reg;
    assign lane_hue   = lane_hue_reg;
    assign lane_sat   = lane_sat_reg;
    assign side       = side_reg;

    // Fit port fields to the channel width, dropping bits above it
    always_comb
    begin
        r_wide = {{CB{1'b0}}, in_data.red_level};
        g_wide = {{CB{1'b0}}, in_data.green_level};
        b_wide = {{CB{1'b0}}, in_data.blue_level};
        r_lvl  = r_wide[CB-1:0];
        g_lvl  = g_wide[CB-1:0];
        b_lvl  = b_wide[CB-1:0];
    end

    // Stage A: find max and min, pick the sextant with red then green priority
    always_comb
    begin
        mx_a_next = r_lvl;
        mn_a_next = r_lvl;
        if (g_lvl > mx_a_next)
        begin
            mx_a_next = g_lvl;
        end
        if (b_lvl > mx_a_next)
        begin
            mx_a_next = b_lvl;
        end
        if (g_lvl < mn_a_next)
        begin
            mn_a_next = g_lvl;
        end
        if (b_lvl < mn_a_next)
        begin
            mn_a_next = b_lvl;
        end
        if (mx_a_next == r_lvl)
        begin
            sel_a_next = rth_pkg::SEXT_RED;
            x_a_next   = g_lvl;
            y_a_next   = b_lvl;
        end
        else if (mx_a_next == g_lvl)
        begin
            sel_a_next = rth_pkg::SEXT_GREEN;
            x_a_next   = b_lvl;
            y_a_next   = r_lvl;
        end
        else
        begin
            sel_a_next = rth_pkg::SEXT_BLUE;
            x_a_next   = r_lvl;
            y_a_next   = g_lvl;
        end
    end

    // Stage B: form rounded dividends and doubled divisors for both lanes
    always_comb
    begin
        delta   = mx_a_reg - mn_a_reg;
        neg     = x_a_reg < y_a_reg;
        mag     = neg ? (y_a_reg - x_a_reg) : (x_a_reg - y_a_reg);
        grey    = (delta == '0);
        num_hue = NW'(mag) * NW'(HUE_SCALE2) + NW'(delta);
        num_sat = (((NW'(delta) << CB) - NW'(delta)) << 1) + NW'(mx_a_reg);
        top_hue = num_hue >> QB;
        top_sat = num_sat >> QB;
        lane_hue_next = {top_hue[DW-1:0], {delta, 1'b0}, num_hue[QB-1:0]};
        lane_sat_next = {top_sat[DW-1:0], {mx_a_reg, 1'b0}, num_sat[QB-1:0]};
        side_next     = {sel_a_reg, neg, grey, mx_a_reg};
    end

    // Valid flags advance when their stage may load
    always_comb
    begin
        a_valid_next = a_ready ? in_valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Payload: load on a taken request, hold otherwise
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            mx_a_reg  <= mx_a_next;
            mn_a_reg  <= mn_a_next;
            x_a_reg   <= x_a_next;
            y_a_reg   <= y_a_next;
            sel_a_reg <= sel_a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            lane_hue_reg <= lane_hue_next;
            lane_sat_reg <= lane_sat_next;
            side_reg     <= side_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rth_div_cell.sv =====
// Divider cell: one restoring quotient bit for the hue and saturation lanes.
`timescale 1ns / 1ps
`default_nettype none

module rth_div_cell #(
    parameter int unsigned DW     = 17,
    parameter int unsigned QB     = 16,
    parameter int unsigned SIDE_W = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output logic                       up_ready,
    input  wire logic [2*DW+QB-1:0]    up_hue,
    input  wire logic [2*DW+QB-1:0]    up_sat,
    input  wire logic [SIDE_W-1:0]     up_side,
    output logic                       down_valid,
    input  wire logic                  down_ready,
    output logic [2*DW+QB-1:0]         down_hue,
    output logic [2*DW+QB-1:0]         down_sat,
    output logic [SIDE_W-1:0]          down_side
);

    localparam int unsigned LW = 2*DW + QB;

    logic              valid_reg, valid_next;
    logic [LW-1:0]     hue_reg, hue_next;
    logic [LW-1:0]     sat_reg, sat_next;
    logic [SIDE_W-1:0] side_reg;

    // One step: bring down the next dividend bit, subtract if it fits
    function automatic logic [LW-1:0] div_step(input logic [LW-1:0] lane);
        logic [DW-1:0] part;
        logic [DW-1:0] dvs;
        logic [QB-1:0] nq;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          fits;
        part  = lane[LW-1 -: DW];
        dvs   = lane[QB +: DW];
        nq    = lane[QB-1:0];
        trial = {part, nq[QB-1]};
        diff  = trial - {1'b0, dvs};
        fits  = (trial >= {1'b0, dvs});
        if (fits)
        begin
            part = diff[DW-1:0];
        end
        else
        begin
            part = trial[DW-1:0];
        end
        nq = {nq[QB-2:0], fits};
        return {part, dvs, nq};
    endfunction

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_hue   = hue_reg;
    assign down_sat   = sat_reg;
    assign down_side  = side_reg;

    always_comb
    begin
        hue_next   = div_step(up_hue);
        sat_next   = div_step(up_sat);
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance the lanes on a taken request
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hue_reg  <= hue_next;
            sat_reg  <= sat_next;
            side_reg <= up_side;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rth_finish.sv =====
// Back end: apply hue sign, offset and wrap, grey override, output register.
`timescale 1ns / 1ps
`default_nettype none

module rth_finish #(
    parameter int unsigned CHANNEL_BITS      = 16,
    parameter int unsigned HUE_FRACTION_BITS = 6,
    parameter int unsigned DW                = 17,
    parameter int unsigned QB                = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output logic                       up_ready,
    input  wire logic [2*DW+QB-1:0]    up_hue,
    input  wire logic [2*DW+QB-1:0]    up_sat,
    input  wire logic [CHANNEL_BITS+3:0] up_side,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rth_pkg::rth_hsv_t          out_data
);

    localparam int unsigned CB       = CHANNEL_BITS;
    localparam int unsigned DEG_UNIT = 2**HUE_FRACTION_BITS;
    localparam int unsigned HUE_FULL = rth_pkg::FULL_TURN * DEG_UNIT;
    localparam int unsigned HX       = $clog2(HUE_FULL + 1) + 1;
    localparam int unsigned OW       = rth_pkg::CHAN_W;
    localparam int unsigned HW       = rth_pkg::HUE_W;

    logic                  valid_reg, valid_next;
    rth_pkg::rth_hsv_t     data_reg, data_next;

    logic [QB-1:0]         q_hue;
    logic [QB-1:0]         q_sat;
    logic [QB+HX-1:0]      q_wide;
    logic [HX-1:0]         q;
    logic [HX-1:0]         base;
    logic [HX-1:0]         hue;
    logic [CB-1:0]         mx;
    logic                  grey;
    logic                  neg;
    rth_pkg::rth_sextant_t sel;
    logic [CB-1:0]         sat;
    logic [CB+QB-1:0]      qs_wide;
    logic [CB+OW-1:0]      sat_wide;
    logic [CB+OW-1:0]      val_wide;
    logic [HX+HW-1:0]      hue_wide;

    assign up_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Unpack the quotients and the side data
    always_comb
    begin
        q_hue  = up_hue[QB-1:0];
        q_sat  = up_sat[QB-1:0];
        mx     = up_side[CB-1:0];
        grey   = up_side[CB];
        neg    = up_side[CB+1];
        sel    = rth_pkg::rth_sextant_t'(up_side[CB+3:CB+2]);
        q_wide = {{HX{1'b0}}, q_hue};
        q      = q_wide[HX-1:0];
    end

    // Pick the sextant offset
    always_comb
    begin
        unique case (sel)
            rth_pkg::SEXT_RED:   base = '0;
            rth_pkg::SEXT_GREEN: base = HX'(rth_pkg::OFFSET_GREEN * DEG_UNIT);
            rth_pkg::SEXT_BLUE:  base = HX'(rth_pkg::OFFSET_BLUE * DEG_UNIT);
            default:             base = '0;
        endcase
    end

    // Apply sign and wrap the hue into one turn
    always_comb
    begin
        if (!neg)
        begin
            hue = base + q;
        end
        else if (q <= base)
        begin
            hue = base - q;
        end
        else
        begin
            hue = HX'(HUE_FULL) - (q - base);
        end
        if (hue >= HX'(HUE_FULL))
        begin
            hue = hue - HX'(HUE_FULL);
        end
        if (grey)
        begin
            hue = '0;
        end
    end

    // Clamp saturation to full scale, zero it for grey
    always_comb
    begin
        qs_wide = {{CB{1'b0}}, q_sat};
        if (grey)
        begin
            sat = '0;
        end
        else if (qs_wide > (CB+QB)'({CB{1'b1}}))
        begin
            sat = '1;
        end
        else
        begin
            sat = qs_wide[CB-1:0];
        end
        sat_wide = {{OW{1'b0}}, sat};
        val_wide = {{OW{1'b0}}, mx};
        hue_wide = {{HW{1'b0}}, hue};
        data_next.hue_angle        = hue_wide[HW-1:0];
        data_next.saturation_level = sat_wide[OW-1:0];
        data_next.value_level      = val_wide[OW-1:0];
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the result on a taken request, hold while the sink stalls
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== sim/hsv_pixel_checker.sv =====
// Checker: watches the pixel and HSV channels, predicts each result and compares in order.
`timescale 1ns / 1ps

module hsv_pixel_checker
    import rth_pkg::*;
#(
    parameter int unsigned HUE_FRACTION_BITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  rth_pixel_t in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  rth_hsv_t   out_data,
    output int         fail_count,
    output int         pending,
    output int         checked
);

    localparam longint unsigned DEG_UNIT   = 64'd1 << HUE_FRACTION_BITS;
    localparam longint unsigned HUE_TURN   = FULL_TURN * DEG_UNIT;
    localparam longint unsigned CHAN_MAX   = (64'd1 << CHAN_W) - 64'd1;
    localparam longint unsigned OFFSET_RED = 0;
    localparam int              SHOW_LIMIT = 10;

    // HSV results still owed by the block, oldest first
    rth_hsv_t pending_hsv[$];

    // Work out hue, saturation and value of one pixel
    function automatic rth_hsv_t hsv_of(rth_pixel_t px);
        logic [63:0]  r, g, b, mx, mn, delta;
        logic [63:0]  a, c, mag, num, q, base, hue, sat;
        rth_sextant_t sext;
        rth_hsv_t     res;
        r = 64'(px.red_level);
        g = 64'(px.green_level);
        b = 64'(px.blue_level);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        hue = 64'd0;
        sat = 64'd0;
        if (delta != 64'd0)
        begin
            // ties go to red first, then green
            if (mx == r)
                sext = SEXT_RED;
            else if (mx == g)
                sext = SEXT_GREEN;
            else
                sext = SEXT_BLUE;
            case (sext)
                SEXT_RED:
                begin
                    a = g; c = b; base = OFFSET_RED * DEG_UNIT;
                end
                SEXT_GREEN:
                begin
                    a = b; c = r; base = OFFSET_GREEN * DEG_UNIT;
                end
                default:
                begin
                    a = r; c = g; base = OFFSET_BLUE * DEG_UNIT;
                end
            endcase
            // round the hue quotient to nearest, halves up, then apply sign and offset
            mag = (a >= c) ? (a - c) : (c - a);
            num = SEXT_SPAN * DEG_UNIT * mag;
            q = (64'd2 * num + delta) / (64'd2 * delta);
            if (a >= c)
                hue = base + q;
            else if (q <= base)
                hue = base - q;
            else
                hue = HUE_TURN - (q - base);
            if (hue >= HUE_TURN)
                hue = hue - HUE_TURN;
            sat = (64'd2 * delta * CHAN_MAX + mx) / (64'd2 * mx);
            if (sat > CHAN_MAX)
                sat = CHAN_MAX;
        end
        res.hue_angle        = hue[HUE_W-1:0];
        res.saturation_level = sat[CHAN_W-1:0];
        res.value_level      = mx[CHAN_W-1:0];
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    // Compare each accepted result, then queue the prediction for each accepted request
    always @(posedge clk)
    begin : watch
        rth_hsv_t want;
        bit       bad;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_hsv.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= SHOW_LIMIT)
                        $display("%t: HSV result h=%0d s=%0d v=%0d with no request waiting",
                                 $realtime, out_data.hue_angle, out_data.saturation_level,
                                 out_data.value_level);
                end
                else
                begin
                    want = pending_hsv.pop_front();
                    checked = checked + 1;
                    bad = 1'b0;
                    if (out_data.hue_angle !== want.hue_angle) bad = 1'b1;
                    if (out_data.saturation_level !== want.saturation_level) bad = 1'b1;
                    if (out_data.value_level !== want.value_level) bad = 1'b1;
                    if (bad)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= SHOW_LIMIT)
                            $display("%t: HSV mismatch exp h=%0d s=%0d v=%0d got h=%0d s=%0d v=%0d",
                                     $realtime, want.hue_angle, want.saturation_level,
                                     want.value_level, out_data.hue_angle,
                                     out_data.saturation_level, out_data.value_level);
                    end
                end
            end
            if (in_valid && in_ready)
                pending_hsv.push_back(hsv_of(in_data));
            pending = pending_hsv.size();
        end
    end

endmodule

// ===== sim/tb_rgb_to_hsv_convert.sv =====
// Testbench top: drives RGB pixel requests into the converter and gives the verdict.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_convert;
    import rth_pkg::*;

    localparam int unsigned HUE_FRACTION_BITS = 6;
    localparam int          RANDOM_PIXELS     = 1200;
    localparam int          CALM_FIRST        = 400;
    localparam int          CALM_LAST         = 650;
    localparam int          DRAIN_LIMIT       = 20000;
    localparam int          SETTLE_CYCLES     = 30;
    localparam logic [15:0] FULL              = 16'hFFFF;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    rth_pixel_t in_data;
    logic       out_valid;
    logic       out_ready;
    rth_hsv_t   out_data;

    int fail_count;
    int pending;
    int checked;
    int directed_sent;
    int random_sent;
    bit calm;

    rgb_to_hsv_convert #(
        .CHANNEL_BITS      (CHAN_W),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    hsv_pixel_checker #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) hsv_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("tb_rgb_to_hsv_convert: errors");
        $finish;
    end

    // Stall the result side at random, except during the calm stretch
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    function automatic rth_pixel_t make_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        rth_pixel_t px;
        px.red_level   = r;
        px.green_level = g;
        px.blue_level  = b;
        return px;
    endfunction

    // Hold one request on the input until it is accepted, idling first at random
    task automatic send_pixel(input rth_pixel_t px);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Random pixel, biased towards greys, ties, full-scale and tiny levels
    function automatic rth_pixel_t rand_pixel();
        logic [15:0] v, w, u;
        v = 16'($urandom_range(16'hFFFF));
        w = 16'($urandom_range(16'hFFFF));
        u = 16'($urandom_range(16'hFFFF));
        case ($urandom_range(9))
            4: return make_pixel(16'($urandom_range(7)), 16'($urandom_range(7)),
                                 16'($urandom_range(7)));
            5: return make_pixel(v, v, v);
            6:
            begin
                // two channels share the maximum
                if (w > v)
                begin
                    u = v; v = w; w = u;
                end
                case ($urandom_range(2))
                    0: return make_pixel(v, v, w);
                    1: return make_pixel(w, v, v);
                    default: return make_pixel(v, w, v);
                endcase
            end
            7:
            begin
                case ($urandom_range(2))
                    0: return make_pixel(FULL, v, w);
                    1: return make_pixel(v, FULL, w);
                    default: return make_pixel(v, w, FULL);
                endcase
            end
            8:
            begin
                // nearly grey: small delta, large rounding steps in hue
                w = (v > 16'hFFF0) ? v - 16'($urandom_range(15)) : v + 16'($urandom_range(15));
                u = (v < 16'h0010) ? v + 16'($urandom_range(15)) : v - 16'($urandom_range(15));
                case ($urandom_range(2))
                    0: return make_pixel(v, w, u);
                    1: return make_pixel(u, v, w);
                    default: return make_pixel(w, u, v);
                endcase
            end
            9:
            begin
                return make_pixel($urandom_range(1) ? FULL : 16'h0000,
                                  $urandom_range(1) ? v : 16'h0000,
                                  $urandom_range(1) ? FULL : u);
            end
            default: return make_pixel(v, w, u);
        endcase
    endfunction

    // Reset, directed corners, random pixels, drain and verdict
    initial
    begin : stimulus
        rth_pixel_t corners[$];
        int         waited;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        calm          = 1'b0;
        directed_sent = 0;
        random_sent   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // black, white and the primaries and secondaries
        corners.push_back(make_pixel(16'h0000, 16'h0000, 16'h0000));
        corners.push_back(make_pixel(FULL, FULL, FULL));
        corners.push_back(make_pixel(FULL, 16'h0000, 16'h0000));
        corners.push_back(make_pixel(16'h0000, FULL, 16'h0000));
        corners.push_back(make_pixel(16'h0000, 16'h0000, FULL));
        corners.push_back(make_pixel(FULL, FULL, 16'h0000));
        corners.push_back(make_pixel(16'h0000, FULL, FULL));
        corners.push_back(make_pixel(FULL, 16'h0000, FULL));
        // grey mid level and alternating bit patterns
        corners.push_back(make_pixel(16'h8000, 16'h8000, 16'h8000));
        corners.push_back(make_pixel(16'hAAAA, 16'h5555, 16'hAAAA));
        corners.push_back(make_pixel(16'h5555, 16'hAAAA, 16'h5555));
        // a channel at the smallest non-zero level
        corners.push_back(make_pixel(16'h0001, 16'h0000, 16'h0000));
        corners.push_back(make_pixel(16'h0000, 16'h0000, 16'h0001));
        corners.push_back(make_pixel(FULL, 16'h0000, 16'h0001));
        // red maximum with blue above green: hue wraps below zero
        corners.push_back(make_pixel(FULL, 16'h0000, 16'hFFFE));
        corners.push_back(make_pixel(16'h1000, 16'h0100, 16'h0FFF));
        // hue quotient and saturation landing exactly on a half
        corners.push_back(make_pixel(16'h0200, 16'h0001, 16'h0000));
        corners.push_back(make_pixel(16'h0002, 16'h0001, 16'h0001));
        // blue maximum with red below green, and green maximum with red above blue
        corners.push_back(make_pixel(16'h0000, 16'h7FFF, FULL));
        corners.push_back(make_pixel(16'hC000, FULL, 16'h4000));
        foreach (corners[i])
        begin
            send_pixel(corners[i]);
            directed_sent = directed_sent + 1;
        end

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            calm = (n >= CALM_FIRST) && (n < CALM_LAST);
            send_pixel(rand_pixel());
            random_sent = random_sent + 1;
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // drain what is still in flight, then let the pipeline settle
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited = waited + 1;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d corner-case and %0d random pixels, including greys, ties and wraps.",
                 directed_sent, random_sent);
        $display("Compared %0d HSV results; %0d still outstanding at the end.", checked, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb_rgb_to_hsv_convert: clean");
        else
            $display("tb_rgb_to_hsv_convert: errors");
        $finish;
    end

endmodule
